/* hw/rtl/spq_pkg.sv */
// Shared constants, types and helpers for the static-priority ready queue.
// No dependencies; every other file of the block uses this package.
package spq_pkg;

  // Storage sizing
  localparam int QUEUE_DEPTH   = 16;
  localparam int TASK_ID_WIDTH = 8;

  // Fixed field widths of the channels
  localparam int CMD_FIELD_W   = 1;
  localparam int TASK_FIELD_W  = 8;
  localparam int PRIO_FIELD_W  = 8;
  localparam int LEVEL_W       = 4;
  localparam int DEPTH_FIELD_W = 5;
  localparam int TOTAL_W       = 32;

  // Bits of an identifier that are actually kept
  localparam int TASK_STORE_W  = (TASK_ID_WIDTH < TASK_FIELD_W) ? TASK_ID_WIDTH : TASK_FIELD_W;

  // Occupancy counter must hold QUEUE_DEPTH itself
  localparam int COUNT_W       = $clog2(QUEUE_DEPTH + 1);

  // Priority band limits
  localparam logic [LEVEL_W-1:0] LEVEL_MIN = LEVEL_W'(0);
  localparam logic [LEVEL_W-1:0] LEVEL_MAX = LEVEL_W'(10);

  // Command codes
  localparam logic [CMD_FIELD_W-1:0] CMD_ENQUEUE  = 1'b0;
  localparam logic [CMD_FIELD_W-1:0] CMD_DISPATCH = 1'b1;

  // One queue entry as held in a cell
  typedef struct packed {
    logic                    valid;
    logic [TASK_STORE_W-1:0] tid;
    logic [LEVEL_W-1:0]      level;
  } entry_t;

  // Per-cycle control broadcast to every cell
  typedef struct packed {
    logic   enq;
    logic   dsp;
    entry_t new_entry;
  } cell_ctl_t;

  // Clamp a signed request into the 0..10 band
  function automatic logic [LEVEL_W-1:0] clamp_level(input logic signed [PRIO_FIELD_W-1:0] req);
    logic [LEVEL_W-1:0] lvl;
    if (req < 0) begin
      lvl = LEVEL_MIN;
    end else if (req > $signed({1'b0, LEVEL_MAX})) begin
      lvl = LEVEL_MAX;
    end else begin
      lvl = req[LEVEL_W-1:0];
    end
    return lvl;
  endfunction

endpackage

/* hw/rtl/spq_if.sv */
// Valid/ready channel interfaces for the ready queue's command and result beats.
// Depends on spq_pkg for field widths.
interface spq_in_if;
  logic                                   valid;
  logic                                   ready;
  logic [spq_pkg::CMD_FIELD_W-1:0]        command;
  logic [spq_pkg::TASK_FIELD_W-1:0]       task_id;
  logic signed [spq_pkg::PRIO_FIELD_W-1:0] priority_req;

  modport source (output valid, command, task_id, priority_req, input ready);
  modport sink   (input valid, command, task_id, priority_req, output ready);
endinterface

interface spq_out_if;
  logic                                valid;
  logic                                ready;
  logic                                dispatched;
  logic [spq_pkg::TASK_FIELD_W-1:0]    out_task_id;
  logic [spq_pkg::LEVEL_W-1:0]         out_priority;
  logic                                dropped;
  logic [spq_pkg::DEPTH_FIELD_W-1:0]   depth;
  logic [spq_pkg::TOTAL_W-1:0]         enqueue_total;
  logic [spq_pkg::TOTAL_W-1:0]         dispatch_total;

  modport source (output valid, dispatched, out_task_id, out_priority, dropped, depth,
                  enqueue_total, dispatch_total, input ready);
  modport sink   (input valid, dispatched, out_task_id, out_priority, dropped, depth,
                  enqueue_total, dispatch_total, output ready);
endinterface

/* hw/rtl/spq_cell.sv */
// One slot of the sorted queue chain: holds an entry, shifts towards the tail
// on insert and towards the head on dispatch. Depends on spq_pkg.
module spq_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  spq_pkg::cell_ctl_t ctl,
  input  logic               left_ins,    // new entry lands at or before the left cell
  input  spq_pkg::entry_t    left_entry,
  input  spq_pkg::entry_t    right_entry,
  output logic               ins_o,       // new entry belongs ahead of this cell's entry
  output spq_pkg::entry_t    entry_o
);
  import spq_pkg::*;

  logic                    valid_r, valid_nxt;
  logic [TASK_STORE_W-1:0] tid_r,   tid_nxt;
  logic [LEVEL_W-1:0]      level_r, level_nxt;

  assign entry_o = '{valid: valid_r, tid: tid_r, level: level_r};

  // Strictly lower level goes first; equal levels keep arrival order
  assign ins_o = !valid_r || (ctl.new_entry.level < level_r);

  // Next contents from neighbours or the incoming entry
  always_comb begin
    valid_nxt = valid_r;
    tid_nxt   = tid_r;
    level_nxt = level_r;
    if (ctl.enq) begin
      if (left_ins) begin
        valid_nxt = left_entry.valid;
        tid_nxt   = left_entry.tid;
        level_nxt = left_entry.level;
      end else if (ins_o) begin
        valid_nxt = 1'b1;
        tid_nxt   = ctl.new_entry.tid;
        level_nxt = ctl.new_entry.level;
      end
    end else if (ctl.dsp) begin
      valid_nxt = right_entry.valid;
      tid_nxt   = right_entry.tid;
      level_nxt = right_entry.level;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Payload needs no reset
  always_ff @(posedge clk) begin
    tid_r   <= tid_nxt;
    level_r <= level_nxt;
  end

endmodule

/* hw/rtl/static_priority_ready_queue_unit.sv */
// Top level of the static-priority ready queue.
// Depends on spq_pkg, spq_if (spq_in_if, spq_out_if) and spq_cell.
//
// Static-priority ready queue. Each command beat either enqueues a task (priority
// clamped to 0..10) or dispatches the waiting task with the lowest priority number,
// oldest first within a band, and every command beat gives exactly one result beat
// with the depth and the running enqueue and dispatch totals. Entries live in a
// QUEUE_DEPTH-long chain of cells kept sorted by level then arrival, so the head
// cell is always the next task to dispatch; an enqueue is placed by every cell
// comparing the new level with its own and shifting towards the tail. A command
// is taken every cycle while the result register is free or being read, and its
// result appears on the following cycle, one beat per cycle while not stalled. An
// enqueue into a full queue is discarded and flagged; a dispatch from an empty
// queue returns a beat with no task. No clearing pass is needed after reset.
module static_priority_ready_queue_unit (
  input  logic      clk,
  input  logic      rst_n,
  spq_in_if.sink    in_bus,
  spq_out_if.source out_bus
);
  import spq_pkg::*;

  // Chain wiring
  cell_ctl_t              ctl;
  entry_t                 cell_entry [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] cell_ins;
  logic [QUEUE_DEPTH-1:0] valid_vec;

  logic accept, is_enq, full, do_enq, do_dsp;

  // Occupancy and totals
  logic [COUNT_W-1:0] count_r,     count_nxt;
  logic [TOTAL_W-1:0] enq_total_r, enq_total_nxt;
  logic [TOTAL_W-1:0] dsp_total_r, dsp_total_nxt;

  // Result register
  logic                     out_valid_r;
  logic                     out_dispatched_r;
  logic [TASK_FIELD_W-1:0]  out_tid_r;
  logic [LEVEL_W-1:0]       out_level_r;
  logic                     out_dropped_r;
  logic [DEPTH_FIELD_W-1:0] out_depth_r;

  // Handshake
  assign in_bus.ready = !out_valid_r || out_bus.ready;
  assign accept       = in_bus.valid && in_bus.ready;
  assign is_enq       = (in_bus.command == CMD_ENQUEUE);
  assign full         = cell_entry[QUEUE_DEPTH-1].valid;
  assign do_enq       = accept && is_enq && !full;
  assign do_dsp       = accept && (in_bus.command == CMD_DISPATCH) && cell_entry[0].valid;

  // Control broadcast to the chain
  assign ctl.enq             = do_enq;
  assign ctl.dsp             = do_dsp;
  assign ctl.new_entry.valid = 1'b1;
  assign ctl.new_entry.tid   = in_bus.task_id[TASK_STORE_W-1:0];
  assign ctl.new_entry.level = clamp_level(in_bus.priority_req);

  // Row of cells, head at index 0
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    logic   l_ins;
    entry_t l_entry, r_entry;
    if (i == 0) begin : g_head
      assign l_ins   = 1'b0;
      assign l_entry = '0;
    end else begin : g_mid
      assign l_ins   = cell_ins[i-1];
      assign l_entry = cell_entry[i-1];
    end
    if (i == QUEUE_DEPTH - 1) begin : g_tail
      assign r_entry = '0;
    end else begin : g_body
      assign r_entry = cell_entry[i+1];
    end
    spq_cell u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .ctl         (ctl),
      .left_ins    (l_ins),
      .left_entry  (l_entry),
      .right_entry (r_entry),
      .ins_o       (cell_ins[i]),
      .entry_o     (cell_entry[i])
    );
    assign valid_vec[i] = cell_entry[i].valid;
  end

  // Counter updates
  always_comb begin
    count_nxt     = count_r;
    enq_total_nxt = enq_total_r;
    dsp_total_nxt = dsp_total_r;
    if (do_enq) begin
      count_nxt     = count_r + COUNT_W'(1);
      enq_total_nxt = enq_total_r + TOTAL_W'(1);
    end else if (do_dsp) begin
      count_nxt     = count_r - COUNT_W'(1);
      dsp_total_nxt = dsp_total_r + TOTAL_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      enq_total_r <= '0;
      dsp_total_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      enq_total_r <= enq_total_nxt;
      dsp_total_r <= dsp_total_nxt;
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (out_bus.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result beat payload, captured on accept
  always_ff @(posedge clk) begin
    if (accept) begin
      out_dispatched_r <= do_dsp;
      out_tid_r        <= do_dsp ? TASK_FIELD_W'(cell_entry[0].tid) : '0;
      out_level_r      <= do_dsp ? cell_entry[0].level : '0;
      out_dropped_r    <= is_enq && full;
      out_depth_r      <= DEPTH_FIELD_W'(count_nxt);
    end
  end

  assign out_bus.valid          = out_valid_r;
  assign out_bus.dispatched     = out_dispatched_r;
  assign out_bus.out_task_id    = out_tid_r;
  assign out_bus.out_priority   = out_level_r;
  assign out_bus.dropped        = out_dropped_r;
  assign out_bus.depth          = out_depth_r;
  assign out_bus.enqueue_total  = enq_total_r;
  assign out_bus.dispatch_total = dsp_total_r;

  // Occupancy count tracks the cells actually holding entries
  a_count_matches: assert property (@(posedge clk) disable iff (!rst_n)
    count_r == COUNT_W'($countones(valid_vec)))
    else $error("occupancy count disagrees with cell valid bits");

  // Valid entries are packed at the head of the chain
  a_packed: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot({1'b0, valid_vec} + {{QUEUE_DEPTH{1'b0}}, 1'b1}))
    else $error("gap in the cell chain");

  // Head never outranked by its successor
  a_head_sorted: assert property (@(posedge clk) disable iff (!rst_n)
    (cell_entry[0].valid && cell_entry[1].valid) |-> (cell_entry[0].level <= cell_entry[1].level))
    else $error("chain not sorted at the head");

  // A successful dispatch is reported on the next beat with a bumped total
  a_dispatch_report: assert property (@(posedge clk) disable iff (!rst_n)
    do_dsp |=> (out_valid_r && out_dispatched_r && dsp_total_r == $past(dsp_total_r) + TOTAL_W'(1)))
    else $error("dispatch not reported");

endmodule

/* bench/tb_static_priority_ready_queue_unit.sv */
// Self-checking bench for static_priority_ready_queue_unit: command beats in, result beats out.
// Depends on spq_pkg and spq_if from the RTL. A local ready-queue predictor supplies
// the expected result for every accepted command.
module tb_static_priority_ready_queue_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import spq_pkg::*;

  // One command beat as queued for the driver
  typedef struct packed {
    logic [CMD_FIELD_W-1:0]         command;
    logic [TASK_FIELD_W-1:0]        task_id;
    logic signed [PRIO_FIELD_W-1:0] priority_req;
  } cmd_beat_t;

  // One result beat, field for field
  typedef struct packed {
    logic                     dispatched;
    logic [TASK_FIELD_W-1:0]  task_id;
    logic [LEVEL_W-1:0]       level;
    logic                     dropped;
    logic [DEPTH_FIELD_W-1:0] depth;
    logic [TOTAL_W-1:0]       enq_total;
    logic [TOTAL_W-1:0]       disp_total;
  } queue_result_t;

  logic clk;
  logic rst_n;

  spq_in_if  in_bus ();
  spq_out_if out_bus ();

  static_priority_ready_queue_unit dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_bus (in_bus),
    .out_bus(out_bus)
  );

  // Clock: 10 ns period, starts low so the first rising edge follows reset set-up
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Predicted queue contents
  logic [TASK_FIELD_W-1:0] slot_task  [QUEUE_DEPTH];
  logic [LEVEL_W-1:0]      slot_level [QUEUE_DEPTH];
  logic [TOTAL_W-1:0]      slot_stamp [QUEUE_DEPTH];
  logic                    slot_used  [QUEUE_DEPTH];
  logic [TOTAL_W-1:0]      arrival_ctr;
  logic [TOTAL_W-1:0]      enq_ctr;
  logic [TOTAL_W-1:0]      disp_ctr;

  cmd_beat_t     pending_cmds[$];
  queue_result_t awaited_results[$];
  cmd_beat_t     held_cmd;

  int unsigned total_cmds;
  int unsigned accepted_cmds;
  int unsigned error_count;
  int unsigned gap_left;
  int unsigned hold_left;
  int unsigned in_phase_beats;
  int unsigned out_phase_cycles;
  bit          in_quiet;
  bit          out_quiet;

  // Coverage tallies for the summary
  int unsigned seen_dispatch;
  int unsigned seen_empty;
  int unsigned seen_drop;
  int unsigned seen_full;

  // Requested priority into the 0..10 band
  function automatic logic [LEVEL_W-1:0] band_of(logic signed [PRIO_FIELD_W-1:0] req);
    int v;
    v = int'(req);
    if (v < int'(LEVEL_MIN)) v = int'(LEVEL_MIN);
    if (v > int'(LEVEL_MAX)) v = int'(LEVEL_MAX);
    return LEVEL_W'(v);
  endfunction

  // Apply one command to the predicted queue and return its result
  function automatic queue_result_t serve_command(cmd_beat_t c);
    queue_result_t r;
    int            slot;
    int            best;
    int            used;
    logic [TOTAL_W-1:0] age;
    logic [TOTAL_W-1:0] best_age;
    r        = '0;
    slot     = -1;
    best     = -1;
    best_age = '0;
    used     = 0;
    if (c.command == CMD_ENQUEUE) begin
      // lowest free slot
      for (int i = QUEUE_DEPTH - 1; i >= 0; i--) begin
        if (!slot_used[i]) slot = i;
      end
      if (slot < 0) begin
        r.dropped = 1'b1;
      end else begin
        slot_task[slot]  = TASK_FIELD_W'(c.task_id[TASK_STORE_W-1:0]);
        slot_level[slot] = band_of(c.priority_req);
        slot_stamp[slot] = arrival_ctr;
        slot_used[slot]  = 1'b1;
        arrival_ctr      = arrival_ctr + 1;
        enq_ctr          = enq_ctr + 1;
      end
    end else begin
      // lowest band first, oldest arrival within a band
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
        if (slot_used[i]) begin
          age = arrival_ctr - slot_stamp[i];
          if (best < 0 || slot_level[i] < slot_level[best] ||
              (slot_level[i] == slot_level[best] && age > best_age)) begin
            best     = i;
            best_age = age;
          end
        end
      end
      if (best >= 0) begin
        r.dispatched    = 1'b1;
        r.task_id       = slot_task[best];
        r.level         = slot_level[best];
        slot_used[best] = 1'b0;
        disp_ctr        = disp_ctr + 1;
      end
    end
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      if (slot_used[i]) used++;
    end
    r.depth      = DEPTH_FIELD_W'(used);
    r.enq_total  = enq_ctr;
    r.disp_total = disp_ctr;
    return r;
  endfunction

  // Idle length: mostly none or short, now and then long
  function automatic int unsigned pick_idle();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  task automatic check_field(string name, longint unsigned want, longint unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      error_count++;
    end
  endtask

  task automatic add_cmd(logic [CMD_FIELD_W-1:0] cmd, int tid, int prio);
    cmd_beat_t c;
    c.command      = cmd;
    c.task_id      = TASK_FIELD_W'(tid);
    c.priority_req = PRIO_FIELD_W'(prio);
    pending_cmds.push_back(c);
  endtask

  // Command driver: predicts on each accepted beat, then presents the next one
  always @(posedge clk) begin
    if (!rst_n) begin
      in_bus.valid <= 1'b0;
    end else begin
      if (in_bus.valid && in_bus.ready) begin
        awaited_results.push_back(serve_command(held_cmd));
        accepted_cmds++;
        in_phase_beats++;
        if (in_phase_beats % 64 == 0) in_quiet = ($urandom_range(0, 3) == 0);
        gap_left = in_quiet ? 0 : pick_idle();
      end
      if (!in_bus.valid || in_bus.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_bus.valid <= 1'b0;
        end else if (pending_cmds.size() != 0) begin
          held_cmd = pending_cmds.pop_front();
          in_bus.command      <= held_cmd.command;
          in_bus.task_id      <= held_cmd.task_id;
          in_bus.priority_req <= held_cmd.priority_req;
          in_bus.valid        <= 1'b1;
        end else begin
          in_bus.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: compares each beat with the oldest prediction, stalls at random
  always @(posedge clk) begin
    queue_result_t want;
    if (!rst_n) begin
      out_bus.ready <= 1'b0;
    end else begin
      if (out_bus.valid && out_bus.ready) begin
        if (awaited_results.size() == 0) begin
          $error("result beat with no command outstanding");
          error_count++;
        end else begin
          want = awaited_results.pop_front();
          check_field("dispatched", want.dispatched, out_bus.dispatched);
          check_field("out_task_id", want.task_id, out_bus.out_task_id);
          check_field("out_priority", want.level, out_bus.out_priority);
          check_field("dropped", want.dropped, out_bus.dropped);
          check_field("depth", want.depth, out_bus.depth);
          check_field("enqueue_total", want.enq_total, out_bus.enqueue_total);
          check_field("dispatch_total", want.disp_total, out_bus.dispatch_total);
          if (want.dispatched) seen_dispatch++;
          // only a dispatch that found nothing leaves depth zero without a task
          if (!want.dispatched && !want.dropped && want.depth == 0) seen_empty++;
          if (want.dropped) seen_drop++;
          if (want.depth == DEPTH_FIELD_W'(QUEUE_DEPTH)) seen_full++;
        end
        hold_left = out_quiet ? 0 : pick_idle();
      end
      out_phase_cycles++;
      if (out_phase_cycles % 64 == 0) out_quiet = ($urandom_range(0, 3) == 0);
      if (hold_left > 0) begin
        hold_left--;
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= 1'b1;
      end
    end
  end

  // Stimulus, reset and end of run
  initial begin
    int unsigned phase_len;
    int unsigned enq_pct;
    int          prio;
    int unsigned roll;
    rst_n               = 1'b0;
    in_bus.valid        = 1'b0;
    in_bus.command      = CMD_ENQUEUE;
    in_bus.task_id      = '0;
    in_bus.priority_req = '0;
    out_bus.ready       = 1'b0;
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      slot_used[i]  = 1'b0;
      slot_task[i]  = '0;
      slot_level[i] = '0;
      slot_stamp[i] = '0;
    end
    arrival_ctr      = '0;
    enq_ctr          = '0;
    disp_ctr         = '0;
    accepted_cmds    = 0;
    error_count      = 0;
    gap_left         = 0;
    hold_left        = 0;
    in_phase_beats   = 0;
    out_phase_cycles = 0;
    in_quiet         = 1'b0;
    out_quiet        = 1'b0;
    seen_dispatch    = 0;
    seen_empty       = 0;
    seen_drop        = 0;
    seen_full        = 0;

    // Directed: dispatch from empty, fill with edge values and ties, overflow, partial drain
    add_cmd(CMD_DISPATCH, 8'hFF, 127);
    add_cmd(CMD_ENQUEUE, 8'h00, -128);
    add_cmd(CMD_ENQUEUE, 8'hFF, 127);
    add_cmd(CMD_ENQUEUE, 8'h01, 0);
    add_cmd(CMD_ENQUEUE, 8'h80, 10);
    add_cmd(CMD_ENQUEUE, 8'h7F, 11);
    add_cmd(CMD_ENQUEUE, 8'h55, -1);
    add_cmd(CMD_ENQUEUE, 8'hAA, 5);
    add_cmd(CMD_ENQUEUE, 8'h10, 5);
    add_cmd(CMD_ENQUEUE, 8'h11, 5);
    add_cmd(CMD_ENQUEUE, 8'h20, 0);
    add_cmd(CMD_ENQUEUE, 8'h21, 10);
    add_cmd(CMD_ENQUEUE, 8'h30, 3);
    add_cmd(CMD_ENQUEUE, 8'h31, 9);
    add_cmd(CMD_ENQUEUE, 8'h40, 1);
    add_cmd(CMD_ENQUEUE, 8'h41, 1);
    add_cmd(CMD_ENQUEUE, 8'h42, -5);
    add_cmd(CMD_ENQUEUE, 8'h99, 2);
    repeat (7) add_cmd(CMD_DISPATCH, $urandom_range(0, 255), $urandom_range(0, 255));

    // Random: phases leaning to fill, balance or drain, so full and empty both recur
    while (pending_cmds.size() < 1150) begin
      phase_len = $urandom_range(20, 80);
      case ($urandom_range(0, 2))
        0: enq_pct = 85;
        1: enq_pct = 50;
        default: enq_pct = 15;
      endcase
      repeat (phase_len) begin
        if ($urandom_range(0, 99) < enq_pct) begin
          roll = $urandom_range(0, 99);
          if (roll < 40)      prio = $urandom_range(0, 3);
          else if (roll < 80) prio = $urandom_range(0, 10);
          else if (roll < 90) prio = int'($signed(8'($urandom_range(0, 255))));
          else begin
            case ($urandom_range(0, 3))
              0: prio = -128;
              1: prio = -1;
              2: prio = 11;
              default: prio = 127;
            endcase
          end
          add_cmd(CMD_ENQUEUE, $urandom_range(0, 255), prio);
        end else begin
          add_cmd(CMD_DISPATCH, $urandom_range(0, 255), $urandom_range(0, 255));
        end
      end
    end
    total_cmds = pending_cmds.size();

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Drain, then wait for any stray beat
    while (accepted_cmds != total_cmds || awaited_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (awaited_results.size() != 0) begin
      $error("%0d results never arrived", awaited_results.size());
      error_count++;
    end

    $display("Ran %0d commands: %0d tasks served, %0d dispatches on an empty queue,",
             total_cmds, seen_dispatch, seen_empty);
    $display("%0d overflow drops and %0d results at full depth.", seen_drop, seen_full);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

/* files.f */
hw/rtl/spq_pkg.sv
hw/rtl/spq_if.sv
hw/rtl/spq_cell.sv
hw/rtl/static_priority_ready_queue_unit.sv
bench/tb_static_priority_ready_queue_unit.sv
